/* rtl/css_pkg.sv */
// Shared types and codes for the cyclic shift sorter.
`timescale 1ns / 1ps

package css_pkg;

	// Command codes carried in the input item
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_SORT   = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	// Status codes returned in the result item
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_FULL       = 2'd1;
	localparam logic [1:0] STAT_RANGE      = 2'd2;
	localparam logic [1:0] STAT_NOT_SORTED = 2'd3;

	// Which pass owns the shared counting sort
	localparam logic [1:0] CALL_FIRST = 2'd0;
	localparam logic [1:0] CALL_ROUND = 2'd1;
	localparam logic [1:0] CALL_FINAL = 2'd2;

	// Requests from the command front end to the sort engine
	typedef struct packed {
		logic sort_go;
		logic sym_we;
	} css_ctl_t;

endpackage

/* rtl/css_sorter.sv */
// Sort engine: string and work memories plus the prefix doubling sequencer.
`timescale 1ns / 1ps

module css_sorter #(
	parameter int MAX_LEN     = 1024,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  css_pkg::css_ctl_t                ctl,
	input  logic [$clog2(MAX_LEN+1)-1:0]     len,
	input  logic [SYMBOL_BITS-1:0]           wr_sym,
	input  logic [$clog2(MAX_LEN)-1:0]       rd_addr,
	output logic [$clog2(MAX_LEN)-1:0]       rd_data,
	output logic                             done
);

	localparam int IW    = $clog2(MAX_LEN);
	localparam int LW    = $clog2(MAX_LEN + 1);
	localparam int HW    = LW + 1;
	localparam int SB    = SYMBOL_BITS;
	localparam int ALPHA = 1 << SYMBOL_BITS;
	localparam int NB    = (MAX_LEN > ALPHA) ? MAX_LEN : ALPHA;
	localparam int KW    = $clog2(NB);
	localparam int JW    = KW + 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_INI  = 5'd1;
	localparam logic [4:0] S_CLR  = 5'd2;
	localparam logic [4:0] S_CNT0 = 5'd3;
	localparam logic [4:0] S_CNT1 = 5'd4;
	localparam logic [4:0] S_CNT2 = 5'd5;
	localparam logic [4:0] S_CNT3 = 5'd6;
	localparam logic [4:0] S_PFX0 = 5'd7;
	localparam logic [4:0] S_PFX1 = 5'd8;
	localparam logic [4:0] S_PLC0 = 5'd9;
	localparam logic [4:0] S_PLC1 = 5'd10;
	localparam logic [4:0] S_PLC2 = 5'd11;
	localparam logic [4:0] S_PLC3 = 5'd12;
	localparam logic [4:0] S_CI0  = 5'd13;
	localparam logic [4:0] S_CI1  = 5'd14;
	localparam logic [4:0] S_CI2  = 5'd15;
	localparam logic [4:0] S_RCHK = 5'd16;
	localparam logic [4:0] S_SH0  = 5'd17;
	localparam logic [4:0] S_SH1  = 5'd18;
	localparam logic [4:0] S_RN0  = 5'd19;
	localparam logic [4:0] S_RN1  = 5'd20;
	localparam logic [4:0] S_RN2  = 5'd21;
	localparam logic [4:0] S_RN3  = 5'd22;
	localparam logic [4:0] S_CP0  = 5'd23;
	localparam logic [4:0] S_CP1  = 5'd24;
	localparam logic [4:0] S_FIN  = 5'd25;
	localparam logic [4:0] S_DONE = 5'd26;

	// Memories and their registered read data
	logic [SB-1:0] sym_mem [MAX_LEN];
	logic [IW-1:0] ord_mem [MAX_LEN];
	logic [IW-1:0] cls_mem [MAX_LEN];
	logic [IW-1:0] scr_mem [MAX_LEN];
	logic [LW-1:0] bkt_mem [NB];

	logic [SB-1:0] sym_rd_q;
	logic [IW-1:0] ord_rd_q, cls_rd_q, scr_rd_q;
	logic [LW-1:0] bkt_rd_q;

	logic [IW-1:0] sym_ra, ord_ra, cls_ra, scr_ra;
	logic [KW-1:0] bkt_ra;
	logic          ord_we, cls_we, scr_we, bkt_we;
	logic [IW-1:0] ord_wa, ord_wd, cls_wa, cls_wd, scr_wa, scr_wd;
	logic [KW-1:0] bkt_wa;
	logic [LW-1:0] bkt_wd;

	// Sequencer state
	logic [4:0]    state_q;
	logic [1:0]    caller_q;
	logic [LW-1:0] n_q, i_q, m_q, acc_q;
	logic [JW-1:0] j_q, nb_q;
	logic [HW-1:0] h_q;
	logic [IW-1:0] x_q, a_q, ah_q, cls_q, ca_q, pca_q, pcah_q;
	logic [KW-1:0] key_q;
	logic [SB-1:0] psym_q;

	logic [LW-1:0] i_nx, acc_nx, bkt_dec;
	logic [JW-1:0] j_nx;
	logic [KW-1:0] key_c;
	logic [IW-1:0] i_idx, cls_ci, cls_rn, shifted, ah_c;
	logic [HW-1:0] p_ext, a_sum;

	assign i_nx    = i_q + LW'(1);
	assign j_nx    = j_q + JW'(1);
	assign i_idx   = i_q[IW-1:0];
	assign acc_nx  = acc_q + bkt_rd_q;
	assign bkt_dec = bkt_rd_q - LW'(1);
	assign key_c   = (caller_q == css_pkg::CALL_FIRST) ? KW'(sym_rd_q) : KW'(cls_rd_q);

	// Rotate a start back by h, and forward by h, modulo the length
	assign p_ext   = HW'(ord_rd_q);
	assign shifted = (p_ext >= h_q) ? IW'(p_ext - h_q) : IW'(p_ext + HW'(n_q) - h_q);
	assign a_sum   = HW'(ord_rd_q) + h_q;
	assign ah_c    = (a_sum >= HW'(n_q)) ? IW'(a_sum - HW'(n_q)) : IW'(a_sum);

	// Class numbering: open a new class where the key changes
	assign cls_ci = (i_q == '0) ? '0 : ((sym_rd_q != psym_q) ? cls_q + IW'(1) : cls_q);
	assign cls_rn = (i_q == '0) ? '0 :
		((ca_q != pca_q || cls_rd_q != pcah_q) ? cls_q + IW'(1) : cls_q);

	assign rd_data = ord_rd_q;
	assign done    = (state_q == S_DONE);

	// Steer memory ports from the current step
	always_comb begin
		sym_ra = '0; ord_ra = '0; cls_ra = '0; scr_ra = '0; bkt_ra = '0;
		ord_we = 1'b0; cls_we = 1'b0; scr_we = 1'b0; bkt_we = 1'b0;
		ord_wa = '0; ord_wd = '0; cls_wa = '0; cls_wd = '0;
		scr_wa = '0; scr_wd = '0; bkt_wa = '0; bkt_wd = '0;
		unique case (state_q)
			S_IDLE: ord_ra = rd_addr;
			S_INI, S_FIN: begin
				scr_we = 1'b1; scr_wa = i_idx; scr_wd = i_idx;
			end
			S_CLR: begin
				bkt_we = 1'b1; bkt_wa = j_q[KW-1:0]; bkt_wd = '0;
			end
			S_CNT0, S_CP0: scr_ra = i_idx;
			S_CNT1, S_PLC1: begin
				sym_ra = scr_rd_q; cls_ra = scr_rd_q;
			end
			S_CNT2, S_PLC2: bkt_ra = key_c;
			S_CNT3: begin
				bkt_we = 1'b1; bkt_wa = key_q; bkt_wd = bkt_rd_q + LW'(1);
			end
			S_PFX0: bkt_ra = j_q[KW-1:0];
			S_PFX1: begin
				bkt_we = 1'b1; bkt_wa = j_q[KW-1:0]; bkt_wd = acc_nx;
			end
			S_PLC0: scr_ra = IW'(i_q - LW'(1));
			S_PLC3: begin
				bkt_we = 1'b1; bkt_wa = key_q; bkt_wd = bkt_dec;
				ord_we = 1'b1; ord_wa = bkt_dec[IW-1:0]; ord_wd = x_q;
			end
			S_CI0, S_SH0, S_RN0: ord_ra = i_idx;
			S_CI1: sym_ra = ord_rd_q;
			S_CI2: begin
				cls_we = 1'b1; cls_wa = a_q; cls_wd = cls_ci;
			end
			S_SH1: begin
				scr_we = 1'b1; scr_wa = i_idx; scr_wd = shifted;
			end
			S_RN1: cls_ra = ord_rd_q;
			S_RN2: cls_ra = ah_q;
			S_RN3: begin
				scr_we = 1'b1; scr_wa = a_q; scr_wd = cls_rn;
			end
			S_CP1: begin
				cls_we = 1'b1; cls_wa = i_idx; cls_wd = scr_rd_q;
			end
			default: ;
		endcase
	end

	// Memory arrays with one write and one registered read each
	always_ff @(posedge clk) begin
		if (ctl.sym_we)
			sym_mem[len[IW-1:0]] <= wr_sym;
		sym_rd_q <= sym_mem[sym_ra];
	end

	always_ff @(posedge clk) begin
		if (ord_we)
			ord_mem[ord_wa] <= ord_wd;
		ord_rd_q <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (cls_we)
			cls_mem[cls_wa] <= cls_wd;
		cls_rd_q <= cls_mem[cls_ra];
	end

	always_ff @(posedge clk) begin
		if (scr_we)
			scr_mem[scr_wa] <= scr_wd;
		scr_rd_q <= scr_mem[scr_ra];
	end

	always_ff @(posedge clk) begin
		if (bkt_we)
			bkt_mem[bkt_wa] <= bkt_wd;
		bkt_rd_q <= bkt_mem[bkt_ra];
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			caller_q <= css_pkg::CALL_FIRST;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (ctl.sort_go) begin
					i_q     <= '0;
					state_q <= S_INI;
				end
				S_INI: begin
					i_q <= i_nx;
					if (i_nx == n_q) begin
						j_q      <= '0;
						caller_q <= css_pkg::CALL_FIRST;
						state_q  <= S_CLR;
					end
				end
				S_CLR: begin
					j_q <= j_nx;
					if (j_nx == nb_q) begin
						i_q     <= '0;
						state_q <= S_CNT0;
					end
				end
				S_CNT0: state_q <= S_CNT1;
				S_CNT1: state_q <= S_CNT2;
				S_CNT2: state_q <= S_CNT3;
				S_CNT3: begin
					i_q <= i_nx;
					if (i_nx == n_q) begin
						j_q     <= '0;
						state_q <= S_PFX0;
					end else begin
						state_q <= S_CNT0;
					end
				end
				S_PFX0: state_q <= S_PFX1;
				S_PFX1: begin
					j_q <= j_nx;
					if (j_nx == nb_q) begin
						i_q     <= n_q;
						state_q <= S_PLC0;
					end else begin
						state_q <= S_PFX0;
					end
				end
				S_PLC0: state_q <= S_PLC1;
				S_PLC1: state_q <= S_PLC2;
				S_PLC2: state_q <= S_PLC3;
				S_PLC3: begin
					if (i_q == LW'(1)) begin
						i_q <= '0;
						case (caller_q)
							css_pkg::CALL_FIRST: state_q <= S_CI0;
							css_pkg::CALL_ROUND: state_q <= S_RN0;
							default:             state_q <= S_DONE;
						endcase
					end else begin
						i_q     <= i_q - LW'(1);
						state_q <= S_PLC0;
					end
				end
				S_CI0: state_q <= S_CI1;
				S_CI1: state_q <= S_CI2;
				S_CI2: begin
					i_q     <= i_nx;
					state_q <= (i_nx == n_q) ? S_RCHK : S_CI0;
				end
				S_RCHK: begin
					i_q <= '0;
					if (h_q < HW'(n_q) && m_q < n_q)
						state_q <= S_SH0;
					else
						state_q <= S_FIN;
				end
				S_SH0: state_q <= S_SH1;
				S_SH1: begin
					i_q <= i_nx;
					if (i_nx == n_q) begin
						j_q      <= '0;
						caller_q <= css_pkg::CALL_ROUND;
						state_q  <= S_CLR;
					end else begin
						state_q <= S_SH0;
					end
				end
				S_RN0: state_q <= S_RN1;
				S_RN1: state_q <= S_RN2;
				S_RN2: state_q <= S_RN3;
				S_RN3: begin
					if (i_nx == n_q) begin
						i_q     <= '0;
						state_q <= S_CP0;
					end else begin
						i_q     <= i_nx;
						state_q <= S_RN0;
					end
				end
				S_CP0: state_q <= S_CP1;
				S_CP1: begin
					i_q     <= i_nx;
					state_q <= (i_nx == n_q) ? S_RCHK : S_CP0;
				end
				S_FIN: begin
					i_q <= i_nx;
					if (i_nx == n_q) begin
						j_q      <= '0;
						caller_q <= css_pkg::CALL_FINAL;
						state_q  <= S_CLR;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (ctl.sort_go)
				n_q <= len;
			S_INI: if (i_nx == n_q)
				nb_q <= JW'(ALPHA);
			S_CLR: acc_q <= '0;
			S_CNT2, S_PLC2: key_q <= key_c;
			S_PFX1: acc_q <= acc_nx;
			S_PLC1: x_q <= scr_rd_q;
			S_CI1: a_q <= ord_rd_q;
			S_CI2: begin
				cls_q  <= cls_ci;
				psym_q <= sym_rd_q;
				if (i_nx == n_q) begin
					m_q <= LW'(cls_ci) + LW'(1);
					h_q <= HW'(1);
				end
			end
			S_SH1: if (i_nx == n_q)
				nb_q <= JW'(m_q);
			S_RN1: begin
				a_q  <= ord_rd_q;
				ah_q <= ah_c;
			end
			S_RN2: ca_q <= cls_rd_q;
			S_RN3: begin
				cls_q  <= cls_rn;
				pca_q  <= ca_q;
				pcah_q <= cls_rd_q;
				if (i_nx == n_q)
					m_q <= LW'(cls_rn) + LW'(1);
			end
			S_CP1: if (i_nx == n_q)
				h_q <= h_q << 1;
			S_FIN: if (i_nx == n_q)
				nb_q <= JW'(n_q);
			default: ;
		endcase
	end

endmodule

/* rtl/cyclic_shift_sorter.sv */
// Top level: command front end, result register and sort engine.
`timescale 1ns / 1ps
// Clear and append items load the result register as they are taken and run one per cycle while
// m_tready keeps up; a read loads it from the read state because the order memory read is registered.
// A sort of n symbols runs counting passes over nb buckets (nb = 2**SYMBOL_BITS, class count or n),
// plus shift, renumber and copy passes per doubling round, over at most ceil(log2(n)) rounds of the
// memory sequencer; the block takes no item meanwhile.
// Reset clears length, sorted flag and handshake state; memories need no clearing pass.

module cyclic_shift_sorter #(
	parameter int MAX_LEN     = 1024,
	parameter int SYMBOL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // symbol[7:0], rank_index[17:8], zero fill
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // start_position[9:0], string_length[20:10], status[22:21]
);

	localparam int IW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = (LW > 10) ? LW : 10;
	localparam int WW = (LW > 11) ? LW : 11;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_READ = 2'd1;
	localparam logic [1:0] T_SORT = 2'd2;

	logic [1:0]    t_state_q;
	logic [LW-1:0] len_q, len_nx;
	logic          sorted_q;
	logic          m_valid_q;
	logic [9:0]    m_pos_q;
	logic [10:0]   m_len_q;
	logic [1:0]    m_stat_q;

	logic             accept, full, in_range, sort_done, m_load;
	logic [1:0]       mode;
	logic [9:0]       rank;
	logic [CW-1:0]    rank_w;
	logic [IW-1:0]    rd_data;
	logic [1:0]       stat_c;
	css_pkg::css_ctl_t ctl;

	assign mode     = s_tuser;
	assign rank     = s_tdata[17:8];
	assign rank_w   = CW'(rank);
	assign accept   = s_tvalid && s_tready;
	assign full     = (len_q >= LW'(MAX_LEN));
	assign in_range = (rank_w < CW'(len_q));
	assign s_tready = (t_state_q == T_IDLE) && (!m_valid_q || m_tready);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_stat_q, m_len_q, m_pos_q};

	// Decode the item into engine requests
	always_comb begin
		ctl.sym_we  = accept && (mode == css_pkg::MODE_APPEND) && !full;
		ctl.sort_go = accept && (mode == css_pkg::MODE_SORT) && (len_q != '0);
	end

	// Next length and immediate status
	always_comb begin
		len_nx = len_q;
		stat_c = css_pkg::STAT_OK;
		unique case (mode)
			css_pkg::MODE_CLEAR: len_nx = '0;
			css_pkg::MODE_APPEND: begin
				if (full)
					stat_c = css_pkg::STAT_FULL;
				else
					len_nx = len_q + LW'(1);
			end
			css_pkg::MODE_SORT: ;
			css_pkg::MODE_READ: begin
				if (!sorted_q)
					stat_c = css_pkg::STAT_NOT_SORTED;
				else if (!in_range)
					stat_c = css_pkg::STAT_RANGE;
			end
			default: ;
		endcase
	end

	// Raise the result valid when a result item is ready this cycle
	always_comb begin
		unique case (t_state_q)
			T_IDLE: m_load = accept && !ctl.sort_go &&
				!((mode == css_pkg::MODE_READ) && sorted_q && in_range);
			T_READ: m_load = 1'b1;
			T_SORT: m_load = sort_done;
			default: m_load = 1'b0;
		endcase
	end

	css_sorter #(
		.MAX_LEN     (MAX_LEN),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_sorter (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.len     (len_q),
		.wr_sym  (SYMBOL_BITS'((SYMBOL_BITS + 8)'(s_tdata[7:0]))),
		.rd_addr (rank_w[IW-1:0]),
		.rd_data (rd_data),
		.done    (sort_done)
	);

	// Command control and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_state_q <= T_IDLE;
			len_q     <= '0;
			sorted_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_load)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			unique case (t_state_q)
				T_IDLE: if (accept) begin
					len_q <= len_nx;
					unique case (mode)
						css_pkg::MODE_CLEAR: sorted_q <= 1'b0;
						css_pkg::MODE_APPEND: begin
							if (!full)
								sorted_q <= 1'b0;
						end
						css_pkg::MODE_SORT: begin
							if (len_q == '0)
								sorted_q <= 1'b1;
							else
								t_state_q <= T_SORT;
						end
						css_pkg::MODE_READ: begin
							if (sorted_q && in_range)
								t_state_q <= T_READ;
						end
						default: ;
					endcase
				end
				T_READ: t_state_q <= T_IDLE;
				T_SORT: if (sort_done) begin
					sorted_q  <= 1'b1;
					t_state_q <= T_IDLE;
				end
				default: t_state_q <= T_IDLE;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		unique case (t_state_q)
			T_IDLE: if (accept) begin
				m_pos_q  <= '0;
				m_len_q  <= 11'(WW'(len_nx));
				m_stat_q <= stat_c;
			end
			T_READ: m_pos_q <= 10'(CW'(rd_data));
			T_SORT: if (sort_done) begin
				m_pos_q  <= '0;
				m_len_q  <= 11'(WW'(len_q));
				m_stat_q <= css_pkg::STAT_OK;
			end
			default: ;
		endcase
	end

	// A started sort holds off the next item
	a_sort_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sort_go |=> !s_tready)
		else $error("input taken while sort runs");

	// The engine finishes only while a sort is pending
	a_done_in_sort: assert property (@(posedge clk) disable iff (!arst_n)
		sort_done |-> (t_state_q == T_SORT))
		else $error("sort done outside a sort");

	// Length never passes capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LEN))
		else $error("length beyond capacity");

endmodule
